@@ rtl/dpsg_pkg.sv @@
// dpsg_pkg: shared types, register addresses, timing constants and the duty table
// for the dual pulse sound generator. Depends on nothing.

package dpsg_pkg;

   // bus addresses of the registers that respond
   localparam logic [15:0] ADDR_NR10 = 16'hFF10;
   localparam logic [15:0] ADDR_NR11 = 16'hFF11;
   localparam logic [15:0] ADDR_NR12 = 16'hFF12;
   localparam logic [15:0] ADDR_NR13 = 16'hFF13;
   localparam logic [15:0] ADDR_NR14 = 16'hFF14;
   localparam logic [15:0] ADDR_NR21 = 16'hFF16;
   localparam logic [15:0] ADDR_NR22 = 16'hFF17;
   localparam logic [15:0] ADDR_NR23 = 16'hFF18;
   localparam logic [15:0] ADDR_NR24 = 16'hFF19;
   localparam logic [15:0] ADDR_NR52 = 16'hFF26;

   // item kinds
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // timing units in ticks
   localparam int ENVELOPE_UNIT_TICKS = 16384;
   localparam int SWEEP_UNIT_TICKS    = 8192;
   localparam int LENGTH_UNIT_TICKS   = 4096;
   localparam int LENGTH_STEPS        = 64;

   // widths
   localparam int PERIOD_W    = 11;
   localparam int SWEEP_TMR_W = 16;
   localparam int ENV_TMR_W   = 17;
   localparam int LENGTH_W    = 19;
   localparam int VOLUME_W    = 4;
   localparam int SAMPLE_W    = 5;

   // channel register select
   typedef enum logic [1:0] {
      CH_REG_DUTY = 2'd0,
      CH_REG_ENV  = 2'd1,
      CH_REG_LOW  = 2'd2,
      CH_REG_HIGH = 2'd3
   } chan_reg_type;

   // register write toward one channel
   typedef struct packed {
      logic         en;
      chan_reg_type sel;
      logic [7:0]   data;
   } chan_write_type;

   // period update from the sweep unit
   typedef struct packed {
      logic                  apply;
      logic [PERIOD_W-1:0]   period;
   } sweep_type;

   // duty patterns selected by NRx1 bits 7..6
   function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
      logic [7:0] pat;
      case (sel)
         2'd0:    pat = 8'h01;
         2'd1:    pat = 8'h03;
         2'd2:    pat = 8'h0F;
         default: pat = 8'hFC;
      endcase
      return pat;
   endfunction

endpackage

@@ rtl/dpsg_if.sv @@
// dpsg_req_if and dpsg_rsp_if: valid/ready channels of the sound generator.
// Depends on dpsg_pkg for field widths.

interface dpsg_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output func, output address, output data, input ready);
   modport sink   (input valid, input func, input address, input data, output ready);
endinterface

interface dpsg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dpsg_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/dual_pulse_sound_generator.sv @@
// dual_pulse_sound_generator: two pulse channels behind byte registers.
// Depends on dpsg_pkg, dpsg_if, dpsg_sweep and dpsg_pulse.
//
//   channel    dir  payload                      word
//   req_chan   in   func, address[15:0], data    register write or one tick
//   rsp_chan   out  sample[4:0]                  mixed level, one per tick
//
// An accepted word is held in the input register, then the state update and the
// mix happen in one pass into the result register, one word per cycle sustained
// while rsp_chan does not stall. The input register refills while a result waits.
// A write produces no result. Synchronous reset clears the valid flags, the power
// bit and the channel and sweep registers to zero; the input word and the sample
// are not reset. A stall on rsp_chan holds the result and, once the input register is full, drops req_chan.ready.

module dual_pulse_sound_generator (
   input  logic       clock,
   input  logic       reset,
   dpsg_req_if.sink   req_chan,
   dpsg_rsp_if.source rsp_chan
);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_func_ff, in_func_in;
   logic [15:0]                   in_address_ff, in_address_in;
   logic [7:0]                    in_data_ff, in_data_in;
   logic                          out_valid_ff, out_valid_in;
   logic [dpsg_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                          power_ff, power_in;

   logic                          advance;
   logic                          is_write, is_tick;
   logic                          sweep_wr;
   dpsg_pkg::chan_write_type      wr_ch1, wr_ch2;
   dpsg_pkg::sweep_type           sweep_ch1, sweep_none;
   logic                          active_ch1, active_ch2;
   logic [dpsg_pkg::PERIOD_W-1:0] period_ch1, period_ch2;
   logic [dpsg_pkg::VOLUME_W-1:0] level_ch1, level_ch2;
   logic                          chan_tick;

   // handshake
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!in_valid_ff || advance);
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.sample = sample_ff;

   assign is_write  = advance && (in_func_ff == dpsg_pkg::FUNC_WRITE);
   assign is_tick   = advance && (in_func_ff == dpsg_pkg::FUNC_TICK);
   assign chan_tick = is_tick && power_ff;

   // address decode
   always_comb begin
      sweep_wr     = 1'b0;
      power_in     = power_ff;
      wr_ch1.en    = 1'b0;
      wr_ch1.sel   = dpsg_pkg::CH_REG_DUTY;
      wr_ch1.data  = in_data_ff;
      wr_ch2.en    = 1'b0;
      wr_ch2.sel   = dpsg_pkg::CH_REG_DUTY;
      wr_ch2.data  = in_data_ff;
      unique case (in_address_ff)
         dpsg_pkg::ADDR_NR10: sweep_wr = is_write;
         dpsg_pkg::ADDR_NR11: begin
            wr_ch1.en = is_write; wr_ch1.sel = dpsg_pkg::CH_REG_DUTY;
         end
         dpsg_pkg::ADDR_NR12: begin
            wr_ch1.en = is_write; wr_ch1.sel = dpsg_pkg::CH_REG_ENV;
         end
         dpsg_pkg::ADDR_NR13: begin
            wr_ch1.en = is_write; wr_ch1.sel = dpsg_pkg::CH_REG_LOW;
         end
         dpsg_pkg::ADDR_NR14: begin
            wr_ch1.en = is_write; wr_ch1.sel = dpsg_pkg::CH_REG_HIGH;
         end
         dpsg_pkg::ADDR_NR21: begin
            wr_ch2.en = is_write; wr_ch2.sel = dpsg_pkg::CH_REG_DUTY;
         end
         dpsg_pkg::ADDR_NR22: begin
            wr_ch2.en = is_write; wr_ch2.sel = dpsg_pkg::CH_REG_ENV;
         end
         dpsg_pkg::ADDR_NR23: begin
            wr_ch2.en = is_write; wr_ch2.sel = dpsg_pkg::CH_REG_LOW;
         end
         dpsg_pkg::ADDR_NR24: begin
            wr_ch2.en = is_write; wr_ch2.sel = dpsg_pkg::CH_REG_HIGH;
         end
         dpsg_pkg::ADDR_NR52: begin
            if (is_write) begin
               power_in = in_data_ff[7];
            end
         end
         default: ;
      endcase
   end

   // channel 1 sweep
   dpsg_sweep u_sweep (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (sweep_wr),
      .wr_data   (in_data_ff),
      .step      (chan_tick && active_ch1),
      .period_in (period_ch1),
      .sweep     (sweep_ch1)
   );

   assign sweep_none = '0;

   dpsg_pulse u_ch1 (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr_ch1),
      .tick   (chan_tick),
      .sweep  (sweep_ch1),
      .active (active_ch1),
      .period (period_ch1),
      .level  (level_ch1)
   );

   dpsg_pulse u_ch2 (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr_ch2),
      .tick   (chan_tick),
      .sweep  (sweep_none),
      .active (active_ch2),
      .period (period_ch2),
      .level  (level_ch2)
   );

   // input and result registers
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_func_in    = in_func_ff;
      in_address_in = in_address_ff;
      in_data_in    = in_data_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in   = 1'b1;
         in_func_in    = req_chan.func;
         in_address_in = req_chan.address;
         in_data_in    = req_chan.data;
      end

      out_valid_in = out_valid_ff;
      sample_in    = sample_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (is_tick) begin
         out_valid_in = 1'b1;
         sample_in    = dpsg_pkg::SAMPLE_W'(level_ch1) + dpsg_pkg::SAMPLE_W'(level_ch2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         power_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         power_ff     <= power_in;
      end
   end

   always_ff @(posedge clock) begin
      in_func_ff    <= in_func_in;
      in_address_ff <= in_address_in;
      in_data_ff    <= in_data_in;
      sample_ff     <= sample_in;
   end

   // channel 2 period is not needed outside the channel
   logic unused_period_ch2;
   assign unused_period_ch2 = ^{period_ch2, active_ch2};

endmodule

@@ rtl/dpsg_sweep.sv @@
// dpsg_sweep: channel 1 frequency sweep, holding NR10 and the sweep timer.
// Depends on dpsg_pkg.

module dpsg_sweep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [7:0]                    wr_data,
   input  logic                          step,
   input  logic [dpsg_pkg::PERIOD_W-1:0] period_in,
   output dpsg_pkg::sweep_type           sweep
);

   logic [6:0]                       sweep_reg_ff, sweep_reg_in;
   logic [dpsg_pkg::SWEEP_TMR_W-1:0] timer_ff, timer_in;
   logic [dpsg_pkg::SWEEP_TMR_W-1:0] timer_inc, timer_limit;
   logic [2:0]                       steps;
   logic [dpsg_pkg::PERIOD_W-1:0]    delta;
   logic [dpsg_pkg::PERIOD_W:0]      up_sum;
   logic                             fire;

   assign steps       = sweep_reg_ff[6:4];
   assign timer_inc   = timer_ff + 1'b1;
   assign timer_limit = dpsg_pkg::SWEEP_TMR_W'(steps * dpsg_pkg::SWEEP_UNIT_TICKS);
   assign fire        = (steps != 3'd0) && (timer_inc >= timer_limit);

   // new period: up saturates at the top, down cannot go below zero
   assign delta  = period_in >> sweep_reg_ff[2:0];
   assign up_sum = {1'b0, period_in} + {1'b0, delta};

   always_comb begin
      sweep.apply = step && fire;
      if (sweep_reg_ff[3]) begin
         sweep.period = up_sum[dpsg_pkg::PERIOD_W] ? '1 : up_sum[dpsg_pkg::PERIOD_W-1:0];
      end else begin
         sweep.period = period_in - delta;
      end
   end

   // register and timer update
   always_comb begin
      sweep_reg_in = sweep_reg_ff;
      timer_in     = timer_ff;
      if (wr_en) begin
         sweep_reg_in = wr_data[6:0];
      end
      if (step) begin
         if (steps == 3'd0 || fire) begin
            timer_in = '0;
         end else begin
            timer_in = timer_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_reg_ff <= '0;
         timer_ff     <= '0;
      end else begin
         sweep_reg_ff <= sweep_reg_in;
         timer_ff     <= timer_in;
      end
   end

endmodule

@@ rtl/dpsg_pulse.sv @@
// dpsg_pulse: one pulse channel with duty stepping, length countdown and envelope.
// Depends on dpsg_pkg.

module dpsg_pulse (
   input  logic                          clock,
   input  logic                          reset,
   input  dpsg_pkg::chan_write_type      wr,
   input  logic                          tick,
   input  dpsg_pkg::sweep_type           sweep,
   output logic                          active,
   output logic [dpsg_pkg::PERIOD_W-1:0] period,
   output logic [dpsg_pkg::VOLUME_W-1:0] level
);

   logic [1:0]                        duty_sel_ff, duty_sel_in;
   logic [7:0]                        env_reg_ff, env_reg_in;
   logic [7:0]                        low_ff, low_in;
   logic                              len_en_ff, len_en_in;
   logic [dpsg_pkg::PERIOD_W-1:0]     period_ff, period_in;
   logic [dpsg_pkg::PERIOD_W-1:0]     counter_ff, counter_in;
   logic [2:0]                        pos_ff, pos_in;
   logic [7:0]                        pattern_ff, pattern_in;
   logic                              wave_ff, wave_in;
   logic [dpsg_pkg::VOLUME_W-1:0]     vol_ff, vol_in;
   logic [dpsg_pkg::ENV_TMR_W-1:0]    env_tmr_ff, env_tmr_in;
   logic [dpsg_pkg::LENGTH_W-1:0]     len_ff, len_in;

   logic                              run;
   logic [dpsg_pkg::PERIOD_W-1:0]     period_cur;
   logic [dpsg_pkg::PERIOD_W:0]       count_sum;
   logic                              duty_step;
   logic                              muted;
   logic [2:0]                        env_steps;
   logic [dpsg_pkg::ENV_TMR_W-1:0]    env_inc, env_limit;

   assign active = env_reg_ff[7:4] != 4'd0;
   assign run    = tick && active;
   assign period = period_ff;

   // duty step when counter + 1 reaches 2048 - period
   assign period_cur = sweep.apply ? sweep.period : period_ff;
   assign count_sum  = {1'b0, counter_ff} + {1'b0, period_cur} + 1'b1;
   assign duty_step  = count_sum[dpsg_pkg::PERIOD_W];

   assign env_steps = env_reg_ff[2:0];
   assign env_inc   = env_tmr_ff + 1'b1;
   assign env_limit = dpsg_pkg::ENV_TMR_W'(env_steps * dpsg_pkg::ENVELOPE_UNIT_TICKS);

   always_comb begin
      duty_sel_in = duty_sel_ff;
      env_reg_in  = env_reg_ff;
      low_in      = low_ff;
      len_en_in   = len_en_ff;
      period_in   = period_ff;
      counter_in  = counter_ff;
      pos_in      = pos_ff;
      pattern_in  = pattern_ff;
      wave_in     = wave_ff;
      vol_in      = vol_ff;
      env_tmr_in  = env_tmr_ff;
      len_in      = len_ff;
      muted       = 1'b0;

      // register writes
      if (wr.en) begin
         case (wr.sel)
            dpsg_pkg::CH_REG_DUTY: begin
               duty_sel_in = wr.data[7:6];
               len_in = dpsg_pkg::LENGTH_W'((dpsg_pkg::LENGTH_STEPS - int'(wr.data[5:0]))
                                            * dpsg_pkg::LENGTH_UNIT_TICKS);
            end
            dpsg_pkg::CH_REG_ENV: begin
               env_reg_in = wr.data;
               vol_in     = wr.data[7:4];
            end
            dpsg_pkg::CH_REG_LOW: begin
               low_in = wr.data;
            end
            default: begin
               len_en_in = wr.data[6];
               period_in = {wr.data[2:0], low_ff};
               if (wr.data[7]) begin
                  counter_in = '0;
               end
            end
         endcase
      end

      // one tick of a running channel
      if (run) begin
         period_in = period_cur;
         if (duty_step) begin
            counter_in = '0;
            if (pos_ff == 3'd0) begin
               pattern_in = dpsg_pkg::duty_pattern(duty_sel_ff);
            end
            wave_in = pattern_in[pos_ff];
            pos_in  = pos_ff + 1'b1;
         end else begin
            counter_in = counter_ff + 1'b1;
         end

         // length countdown
         if (len_en_ff) begin
            if (len_ff == '0) begin
               muted = 1'b1;
            end else begin
               len_in = len_ff - 1'b1;
            end
         end

         // envelope
         if (env_steps != 3'd0) begin
            if (env_inc >= env_limit) begin
               env_tmr_in = '0;
               if (env_reg_ff[3]) begin
                  if (vol_ff != '1) begin
                     vol_in = vol_ff + 1'b1;
                  end
               end else if (vol_ff != '0) begin
                  vol_in = vol_ff - 1'b1;
               end
            end else begin
               env_tmr_in = env_inc;
            end
         end else begin
            env_tmr_in = '0;
         end
      end

      level = (run && !muted && wave_in) ? vol_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_sel_ff <= '0;
         env_reg_ff  <= '0;
         low_ff      <= '0;
         len_en_ff   <= 1'b0;
         period_ff   <= '0;
         counter_ff  <= '0;
         pos_ff      <= '0;
         pattern_ff  <= '0;
         wave_ff     <= 1'b0;
         vol_ff      <= '0;
         env_tmr_ff  <= '0;
         len_ff      <= '0;
      end else begin
         duty_sel_ff <= duty_sel_in;
         env_reg_ff  <= env_reg_in;
         low_ff      <= low_in;
         len_en_ff   <= len_en_in;
         period_ff   <= period_in;
         counter_ff  <= counter_in;
         pos_ff      <= pos_in;
         pattern_ff  <= pattern_in;
         wave_ff     <= wave_in;
         vol_ff      <= vol_in;
         env_tmr_ff  <= env_tmr_in;
         len_ff      <= len_in;
      end
   end

endmodule

@@ rtl/dpsg_checker.sv @@
// dpsg_checker: port-level checks of the sound generator, bound to the top level.
// Depends on dpsg_pkg.

module dpsg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_func,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dpsg_pkg::SAMPLE_W-1:0] rsp_sample
);

   // a stalled result word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("result word changed while stalled");

   // two full-scale channels at most
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample <= 5'd30)
      else $error("sample above the mix range");

   // a new result comes from a tick that passed through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_func == dpsg_pkg::FUNC_TICK, 2))
      else $error("result word without a matching tick");

   // no result word right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule

bind dual_pulse_sound_generator dpsg_checker u_dpsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_func   (req_chan.func),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample)
);
